// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the hashed TLB page walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define HTLB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define HTLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/htlb_pkg.sv =====
// Types and constants of the hashed TLB page walker.
package htlb_pkg;

  localparam int unsigned SETS_DEFAULT = 64;
  localparam int unsigned ENTRY_W      = 40;  // tag [39:20], physical page [19:0]
  localparam int unsigned PAGE_W       = 20;
  localparam int unsigned VALID_BIT    = 8;
  localparam logic [31:0] SEG_MASK     = 32'h1FFF_FFFF;
  localparam logic [2:0]  SEG_MAPPED   = 3'd6;
  localparam logic [2:0]  SEG_UNMAPPED = 3'd7;

  typedef enum logic [0:0] {
    OP_TRANSLATE = 1'b0,
    OP_RESPONSE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_PHYS  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FAULT = 2'd2
  } result_kind_e;

  typedef enum logic [0:0] {
    REG_TRANSLATE_ENABLE = 1'b0,
    REG_TABLE_BASE       = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_INDEX,
    S_LOOKUP,
    S_WAIT_DIR,
    S_WAIT_PTE,
    S_FILL
  } state_e;

endpackage

// ===== rtl/htlb_ram.sv =====
// Single-port-write, single-port-read TLB memory with registered read data.
module htlb_ram
  import htlb_pkg::*;
#(
  parameter int unsigned DEPTH = SETS_DEFAULT,
  parameter int unsigned WIDTH = 2 * ENTRY_W
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hashed_tlb_page_walker_unit.sv =====
// Hashed 2-way TLB with two-level page walk; one set row {way1, way0} per memory entry.
// Segment bypass and disabled translation give their result in the cycle after start;
// a TLB lookup (busy meanwhile) registers its result after multiply, set index, memory read.
// A walk response is answered in the cycle after it is taken, a fill after state S_FILL.
// Reset: a clearing pass zeroes every TLB set, one set per cycle, with busy held high.
module hashed_tlb_page_walker_unit
  import htlb_pkg::*;
#(
  parameter int unsigned TLB_SETS = SETS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] read_data_i,
  output logic        result_valid_o,
  output logic [1:0]  result_kind_o,
  output logic [31:0] out_address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  `include "assert_macros.svh"

  localparam int unsigned SET_W  = $clog2(TLB_SETS);
  localparam int unsigned ROW_W  = 2 * ENTRY_W;
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / TLB_SETS);
  localparam logic [16:0] SETS17 = 17'(TLB_SETS);
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(TLB_SETS - 1);

  state_e             state_q, state_d;
  logic [31:0]        va_q, va_d;
  logic [15:0]        h16_q, h16_d;
  logic [15:0]        quo_q, quo_d;
  logic [SET_W-1:0]   set_q, set_d;
  logic [PAGE_W-1:0]  pte_q, pte_d;
  logic [SET_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic               res_valid_q, res_valid_d;
  result_kind_e       res_kind_q, res_kind_d;
  logic [31:0]        res_addr_q, res_addr_d;
  logic               en_q;
  logic [19:0]        base_q;

  logic               mem_we, mem_re;
  logic [SET_W-1:0]   mem_waddr, mem_raddr;
  logic [ROW_W-1:0]   mem_wdata, mem_rdata;

  logic               accept;
  logic [19:0]        in_page;
  logic [31:0]        hash_full;
  logic [47:0]        prod;
  logic [16:0]        qn, diff, rem;
  logic [SET_W-1:0]   set_idx;
  logic [ENTRY_W-1:0] way0, way1;
  logic               hit0, hit1;
  logic               lookup_miss;

  // take input only while idle or waiting on a walk response
  assign busy   = (state_q != S_IDLE) && (state_q != S_WAIT_DIR) && (state_q != S_WAIT_PTE);
  assign accept = start && !busy;

  // page * 65521 mod 2^32, formed as page*65536 - page*16 + page
  assign in_page   = address_i[31:12];
  assign hash_full = 32'({in_page, 16'b0}) - 32'({in_page, 4'b0}) + 32'(in_page);

  // Set index = h16 mod TLB_SETS; the reciprocal quotient is low by at most one
  assign prod    = 48'(h16_q) * 48'(RECIP);
  assign qn      = 17'({1'b0, quo_q} * SETS17);
  assign diff    = {1'b0, h16_q} - qn;
  assign rem     = (diff >= SETS17) ? diff - SETS17 : diff;
  assign set_idx = rem[SET_W-1:0];

  assign way0 = mem_rdata[ENTRY_W-1:0];
  assign way1 = mem_rdata[ROW_W-1:ENTRY_W];
  assign hit0 = (way0[ENTRY_W-1:PAGE_W] == va_q[31:12]);
  assign hit1 = (way1[ENTRY_W-1:PAGE_W] == va_q[31:12]);
  assign lookup_miss = (state_q == S_LOOKUP) && !hit0 && !hit1;

  always_comb begin
    state_d     = state_q;
    va_d        = va_q;
    h16_d       = h16_q;
    quo_d       = quo_q;
    set_d       = set_q;
    pte_d       = pte_q;
    clr_cnt_d   = clr_cnt_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_addr_d  = res_addr_q;
    mem_we      = 1'b0;
    mem_waddr   = set_q;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = set_q;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_SET) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && opcode_i == OP_TRANSLATE) begin
          va_d  = address_i;
          h16_d = hash_full[31:16];
          if (address_i[31:29] == SEG_UNMAPPED) begin
            res_valid_d = 1'b1;
            res_kind_d  = KIND_PHYS;
            res_addr_d  = address_i;
          end else if ((address_i[31] && address_i[31:29] != SEG_MAPPED) || !en_q) begin
            res_valid_d = 1'b1;
            res_kind_d  = KIND_PHYS;
            res_addr_d  = address_i & SEG_MASK;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        quo_d   = prod[47:32];
        state_d = S_INDEX;
      end
      S_INDEX: begin
        set_d     = set_idx;
        mem_re    = 1'b1;
        mem_raddr = set_idx;
        state_d   = S_LOOKUP;
      end
      S_LOOKUP: begin
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (hit0) begin
          res_kind_d = KIND_PHYS;
          res_addr_d = {way0[PAGE_W-1:0], va_q[11:0]};
        end else if (hit1) begin
          // swap ways so the hit entry becomes way 0
          res_kind_d = KIND_PHYS;
          res_addr_d = {way1[PAGE_W-1:0], va_q[11:0]};
          mem_we     = 1'b1;
          mem_wdata  = {way0, way1};
        end else begin
          res_kind_d = KIND_READ;
          res_addr_d = {base_q, 12'b0} + {20'b0, va_q[31:22], 2'b0};
          state_d    = S_WAIT_DIR;
        end
      end
      S_WAIT_DIR: begin
        if (accept && opcode_i == OP_RESPONSE) begin
          res_valid_d = 1'b1;
          if (!read_data_i[VALID_BIT]) begin
            res_kind_d = KIND_FAULT;
            res_addr_d = va_q;
            state_d    = S_IDLE;
          end else begin
            res_kind_d = KIND_READ;
            res_addr_d = {read_data_i[31:12], 12'b0} + {20'b0, va_q[21:12], 2'b0};
            state_d    = S_WAIT_PTE;
          end
        end
      end
      S_WAIT_PTE: begin
        if (accept && opcode_i == OP_RESPONSE) begin
          if (!read_data_i[VALID_BIT]) begin
            res_valid_d = 1'b1;
            res_kind_d  = KIND_FAULT;
            res_addr_d  = va_q;
            state_d     = S_IDLE;
          end else begin
            // fetch the set row so the old way 0 can move to way 1
            pte_d   = read_data_i[31:12];
            mem_re  = 1'b1;
            state_d = S_FILL;
          end
        end
      end
      S_FILL: begin
        mem_we      = 1'b1;
        mem_wdata   = {way0, va_q[31:12], pte_q};
        res_valid_d = 1'b1;
        res_kind_d  = KIND_PHYS;
        res_addr_d  = {pte_q, va_q[11:0]};
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      en_q        <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_TRANSLATE_ENABLE: en_q   <= cfg_data_i[0];
          REG_TABLE_BASE:       base_q <= cfg_data_i[31:12];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q       <= va_d;
    h16_q      <= h16_d;
    quo_q      <= quo_d;
    set_q      <= set_d;
    pte_q      <= pte_d;
    res_kind_q <= res_kind_d;
    res_addr_q <= res_addr_d;
  end

  htlb_ram #(
    .DEPTH (TLB_SETS),
    .WIDTH (ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign result_kind_o  = res_kind_q;
  assign out_address_o  = res_addr_q;

  `HTLB_ASSERT(a_no_rw_same_cycle, !(mem_we && mem_re), "TLB read and write in one cycle")
  `HTLB_ASSERT_NEXT(a_miss_issues_read, lookup_miss,
    res_valid_q && res_kind_q == KIND_READ && state_q == S_WAIT_DIR, "miss without directory read")
  `HTLB_ASSERT_NEXT(a_fill_gives_phys, state_q == S_FILL,
    res_valid_q && res_kind_q == KIND_PHYS && state_q == S_IDLE, "fill without physical result")
  `HTLB_ASSERT_NEXT(a_clear_advances, state_q == S_CLEAR && clr_cnt_q != LAST_SET,
    state_q == S_CLEAR && clr_cnt_q == SET_W'($past(clr_cnt_q) + 1'b1), "clear pass stalled")

endmodule
